// ----- sv/cfa_pkg.sv -----
`timescale 1ns / 1ps

package cfa_pkg;

  // Operand width of the arithmetic folds (32 to 64).
  localparam int DW = 64;
  localparam logic [63:0] DW_MASK = {64{1'b1}} >> (64 - DW);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_SDIV   = 4'd3;
  localparam logic [3:0] OP_SREM   = 4'd4;
  localparam logic [3:0] OP_AND    = 4'd5;
  localparam logic [3:0] OP_OR     = 4'd6;
  localparam logic [3:0] OP_XOR    = 4'd7;
  localparam logic [3:0] OP_SHL    = 4'd8;
  localparam logic [3:0] OP_LSHR   = 4'd9;
  localparam logic [3:0] OP_ASHR   = 4'd10;
  localparam logic [3:0] OP_ICMP   = 4'd11;
  localparam logic [3:0] OP_SELECT = 4'd12;

  localparam logic [3:0] CC_EQ  = 4'd0;
  localparam logic [3:0] CC_NE  = 4'd1;
  localparam logic [3:0] CC_SGT = 4'd2;
  localparam logic [3:0] CC_SGE = 4'd3;
  localparam logic [3:0] CC_SLT = 4'd4;
  localparam logic [3:0] CC_SLE = 4'd5;
  localparam logic [3:0] CC_UGT = 4'd6;
  localparam logic [3:0] CC_UGE = 4'd7;
  localparam logic [3:0] CC_ULT = 4'd8;
  localparam logic [3:0] CC_ULE = 4'd9;

  localparam logic [2:0] OUT_NONE   = 3'd0;
  localparam logic [2:0] OUT_CONST  = 3'd1;
  localparam logic [2:0] OUT_FIRST  = 3'd2;
  localparam logic [2:0] OUT_SECOND = 3'd3;
  localparam logic [2:0] OUT_THIRD  = 3'd4;

  // What the back end still has to do with a request.
  typedef enum logic [1:0] {
    K_DONE,
    K_MUL,
    K_DIV
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        rem;
    logic [2:0]  outcome;
    logic [63:0] a;
    logic [63:0] b;
  } cfa_item_t;

  function automatic logic [63:0] sext(input logic [63:0] x);
    return x[DW-1] ? (x | ~DW_MASK) : (x & DW_MASK);
  endfunction

endpackage

// ----- sv/cfa_in_if.sv -----
`timescale 1ns / 1ps

interface cfa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [3:0]  compare_condition;
  logic signed [63:0] lhs_value;
  logic signed [63:0] rhs_value;
  logic signed [63:0] third_value;
  logic        lhs_is_const;
  logic        rhs_is_const;
  logic        wide_compare;

  modport source (output valid, operation, compare_condition, lhs_value, rhs_value,
                  third_value, lhs_is_const, rhs_is_const, wide_compare, input ready);
  modport sink (input valid, operation, compare_condition, lhs_value, rhs_value,
                third_value, lhs_is_const, rhs_is_const, wide_compare, output ready);
endinterface

// ----- sv/cfa_out_if.sv -----
`timescale 1ns / 1ps

interface cfa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic signed [63:0] value;

  modport source (output valid, outcome, value, input ready);
  modport sink (input valid, outcome, value, output ready);
endinterface

// ----- sv/cfa_front.sv -----
`timescale 1ns / 1ps

module cfa_front import cfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cfa_in_if.sink    req,
  output logic      item_valid,
  output cfa_item_t item,
  input  logic      item_ready
);

  logic [63:0] sa, sb, ua, ub, shifted;
  logic        lc, rc, rz, lz, r1, l1, big;
  logic        na, nb, slt, sgt, cmp;
  logic [5:0]  amt;
  logic [2:0]  ident;
  cfa_item_t   cls;

  assign req.ready = !item_valid || item_ready;

  always_comb begin
    lc = req.lhs_is_const;
    rc = req.rhs_is_const;
    sa = sext(req.lhs_value);
    sb = sext(req.rhs_value);
    rz = rc && (sb == 64'd0);
    lz = lc && (sa == 64'd0);
    r1 = rc && (sb == 64'd1);
    l1 = lc && (sa == 64'd1);
    amt = sb[5:0];
    big = ({1'b0, amt} >= 7'(DW));

    ident = OUT_NONE;
    case (req.operation)
      OP_ADD, OP_OR, OP_XOR: begin
        if (rz) ident = OUT_FIRST;
        else if (lz) ident = OUT_SECOND;
      end
      OP_SUB: begin
        if (rz) ident = OUT_FIRST;
      end
      OP_MUL: begin
        if (rz) ident = OUT_SECOND;
        else if (lz) ident = OUT_FIRST;
        else if (r1) ident = OUT_FIRST;
        else if (l1) ident = OUT_SECOND;
      end
      OP_SDIV: begin
        if (r1) ident = OUT_FIRST;
      end
      OP_AND: begin
        if (rz) ident = OUT_SECOND;
        else if (lz) ident = OUT_FIRST;
      end
      default: ident = OUT_NONE;
    endcase

    // The compare works on the raw operands at 32 or 64 bits.
    ua = req.wide_compare ? req.lhs_value : {32'd0, req.lhs_value[31:0]};
    ub = req.wide_compare ? req.rhs_value : {32'd0, req.rhs_value[31:0]};
    na = req.wide_compare ? ua[63] : ua[31];
    nb = req.wide_compare ? ub[63] : ub[31];
    slt = (na != nb) ? na : (ua < ub);
    sgt = (na != nb) ? nb : (ua > ub);
    case (req.compare_condition)
      CC_EQ:  cmp = (ua == ub);
      CC_NE:  cmp = (ua != ub);
      CC_SGT: cmp = sgt;
      CC_SGE: cmp = !slt;
      CC_SLT: cmp = slt;
      CC_SLE: cmp = !sgt;
      CC_UGT: cmp = (ua > ub);
      CC_UGE: cmp = (ua >= ub);
      CC_ULT: cmp = (ua < ub);
      CC_ULE: cmp = (ua <= ub);
      default: cmp = 1'b0;
    endcase

    case (req.operation)
      OP_SHL:  shifted = big ? 64'd0 : (sa << amt);
      OP_LSHR: shifted = big ? 64'd0 : ((sa & DW_MASK) >> amt);
      default: shifted = big ? {64{sa[63]}} : 64'($signed(sa) >>> amt);
    endcase

    cls = '{kind: K_DONE, rem: 1'b0, outcome: OUT_NONE, a: 64'd0, b: 64'd0};
    if (req.operation <= OP_ASHR) begin
      if (ident != OUT_NONE) begin
        cls.outcome = ident;
      end else if (lc && rc) begin
        cls.outcome = OUT_CONST;
        case (req.operation)
          OP_ADD: cls.a = sext(sa + sb);
          OP_SUB: cls.a = sext(sa - sb);
          OP_MUL: begin
            cls.kind = K_MUL;
            cls.a = sa;
            cls.b = sb;
          end
          OP_SDIV, OP_SREM: begin
            if (sb == 64'd0) begin
              cls.outcome = OUT_NONE;
            end else begin
              cls.kind = K_DIV;
              cls.rem = (req.operation == OP_SREM);
              cls.a = sa;
              cls.b = sb;
            end
          end
          OP_AND: cls.a = sa & sb;
          OP_OR:  cls.a = sa | sb;
          OP_XOR: cls.a = sa ^ sb;
          default: cls.a = sext(shifted);
        endcase
      end
    end else if (req.operation == OP_ICMP) begin
      if (lc && rc) begin
        cls.outcome = OUT_CONST;
        cls.a = {63'd0, cmp};
      end
    end else if (req.operation == OP_SELECT) begin
      if (lc) cls.outcome = (sa != 64'd0) ? OUT_SECOND : OUT_THIRD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      item <= cls;
    end
  end

endmodule

// ----- sv/cfa_queue.sv -----
`timescale 1ns / 1ps

module cfa_queue import cfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  cfa_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output cfa_item_t pop_item,
  input  logic      pop
);

  cfa_item_t        mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;
  logic             do_push, do_pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

// ----- sv/cfa_back.sv -----
`timescale 1ns / 1ps

module cfa_back import cfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cfa_item_t head,
  output logic      pop,
  cfa_out_if.source res
);

  // Stage one: operand products or a finished value.
  logic        s1_valid, s1_mul;
  logic [2:0]  s1_outcome;
  logic [63:0] s1_value, p0;
  logic [31:0] p1, p2;
  // Output register.
  logic        s2_valid;
  logic [2:0]  s2_outcome;
  logic [63:0] s2_value;
  // Divider.
  logic        dv_busy, dv_done, dv_rem, dv_na, dv_nb;
  logic [5:0]  dv_cnt;
  logic [63:0] dv_r, dv_q, dv_d, dv_res;
  logic [64:0] trial, diff;

  logic adv2, ld1, from_head, start_div, take_div;
  logic [63:0] mulsum;

  assign adv2 = !s2_valid || res.ready;
  assign ld1 = !s1_valid || adv2;
  assign take_div = dv_done && ld1;
  assign start_div = !dv_busy && !dv_done && head_valid && (head.kind == K_DIV);
  assign from_head = !dv_busy && !dv_done && head_valid && (head.kind != K_DIV) && ld1;
  assign pop = start_div || from_head;

  assign mulsum = p0 + {p1 + p2, 32'd0};
  assign trial = {dv_r, dv_q[63]};
  assign diff = trial - {1'b0, dv_d};
  assign dv_res = dv_rem ? (dv_na ? -dv_r : dv_r) : ((dv_na != dv_nb) ? -dv_q : dv_q);

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else if (start_div) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && dv_cnt == 6'd0) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b1;
    end else if (take_div) begin
      dv_done <= 1'b0;
    end
    if (start_div) begin
      dv_rem <= head.rem;
      dv_na <= head.a[63];
      dv_nb <= head.b[63];
      dv_q <= head.a[63] ? -head.a : head.a;
      dv_d <= head.b[63] ? -head.b : head.b;
      dv_r <= 64'd0;
      dv_cnt <= 6'd63;
    end else if (dv_busy) begin
      dv_cnt <= dv_cnt - 1'b1;
      if (!diff[64]) begin
        dv_r <= diff[63:0];
        dv_q <= {dv_q[62:0], 1'b1};
      end else begin
        dv_r <= trial[63:0];
        dv_q <= {dv_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ld1) s1_valid <= take_div || from_head;
      if (adv2) s2_valid <= s1_valid;
    end
    if (take_div) begin
      s1_mul <= 1'b0;
      s1_outcome <= OUT_CONST;
      s1_value <= sext(dv_res);
    end else if (from_head) begin
      s1_mul <= (head.kind == K_MUL);
      s1_outcome <= head.outcome;
      s1_value <= head.a;
      p0 <= head.a[31:0] * head.b[31:0];
      p1 <= 32'(head.a[31:0] * head.b[63:32]);
      p2 <= 32'(head.a[63:32] * head.b[31:0]);
    end
    if (adv2 && s1_valid) begin
      s2_outcome <= s1_outcome;
      s2_value <= s1_mul ? sext(mulsum) : s1_value;
    end
  end

  assign res.valid = s2_valid;
  assign res.outcome = s2_outcome;
  assign res.value = s2_value;

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.outcome != OUT_CONST |-> res.value == 64'd0)
    else $error("nonzero value without a constant outcome");
  a_div_excl: assert property (@(posedge clk) disable iff (rst)
    !(dv_busy && dv_done))
    else $error("divider busy and done together");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    dv_busy |-> !pop)
    else $error("queue popped while divider busy");
  a_div_result: assert property (@(posedge clk) disable iff (rst)
    take_div |=> s1_valid && s1_outcome == OUT_CONST)
    else $error("division result not loaded");

endmodule

// ----- sv/constant_fold_alu_core.sv -----
`timescale 1ns / 1ps

// Constant folding ALU. Each request on the req channel is one instruction
// (operation, up to three operands, constness flags, compare condition and
// width). One result per request leaves on the res channel, in order: an
// outcome code and, for a folded constant, its value.
// Both channels use valid/ready; a transfer happens when both are high.
// The front end registers each request after applying the identity rules
// and folding add, sub, logic, shift, compare and select. A four-entry
// queue separates it from the back end, which runs a two-stage multiplier
// built from 32-bit partial products and a radix-2 divider.
// Results pass the front register, queue, stage one and output register;
// a signed divide or remainder also runs the divider, and later requests
// wait behind it to keep order. Others sustain one per cycle if unstalled.
// Reset (rst, synchronous) empties the queue and all pipeline stages.
// When the receiver holds ready low, the output register holds its result,
// the back end stops, the queue fills, and req.ready drops once it is full.
module constant_fold_alu_core import cfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cfa_in_if.sink    req,
  cfa_out_if.source res
);

  logic      f_valid, f_ready, q_valid, q_pop;
  cfa_item_t f_item, q_item;

  cfa_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .item_valid(f_valid), .item(f_item), .item_ready(f_ready)
  );

  cfa_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_item(f_item), .push_ready(f_ready),
    .pop_valid(q_valid), .pop_item(q_item), .pop(q_pop)
  );

  cfa_back u_back (
    .clk(clk), .rst(rst),
    .head_valid(q_valid), .head(q_item), .pop(q_pop), .res(res)
  );

endmodule
